// ===== sv/lru_cache_hit_cost_tracker_core_macros.svh =====
// assertion macros for the lru cache hit cost tracker
`ifndef LRU_CACHE_HIT_COST_TRACKER_CORE_MACROS_SVH
`define LRU_CACHE_HIT_COST_TRACKER_CORE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define LCHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcht assertion failed");

// next-cycle implication, checked while out of reset
`define LCHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcht assertion failed");

`endif

// ===== sv/lcht_pkg.sv =====
// shared constants, types and key folding for the lru cache hit cost tracker
`timescale 1ns / 1ps

package lcht_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int KEY_CHARS   = 8;

    localparam int KEY_W  = 64;
    localparam int CAP_W  = 6;
    localparam int COST_W = 32;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [COST_W-1:0] HIT_COST  = COST_W'(1);
    localparam logic [COST_W-1:0] MISS_COST = COST_W'(5);

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // lookup data broadcast to every cell
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] occ;
    } lookup_t;

    // update decision broadcast to every cell
    typedef struct packed {
        logic             en;
        logic             hit;
        logic             evict;
        logic             insert;
        logic [CNT_W-1:0] last;
    } action_t;

    // fold A-Z to lower case, drop bytes above KEY_CHARS
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        logic [7:0]       b;
        k = '0;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            b = raw[8*i +: 8];
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
            begin
                b = b + CASE_OFFSET;
            end
            k[8*i +: 8] = b;
        end
        return k;
    endfunction

endpackage

// ===== sv/lcht_cell.sv =====
// one entry of the lru key chain: holds a key, matches, shifts from its younger neighbor
`timescale 1ns / 1ps

module lcht_cell
    import lcht_pkg::*;
(
    input  logic             clk,
    input  logic [CNT_W-1:0] idx,
    input  lookup_t          lkp,
    input  action_t          act,
    input  logic             seen_in,
    input  logic [KEY_W-1:0] nbr_key,
    output logic             seen_out,
    output logic [KEY_W-1:0] key_out
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             in_use;
    logic             match;
    logic             shift;
    logic             load;

    assign in_use   = idx < lkp.occ;
    assign match    = in_use && (key_reg == lkp.key);
    // set from the matching entry upward
    assign seen_out = seen_in | match;
    assign key_out  = key_reg;

    always_comb
    begin
        shift = ((act.hit && seen_out) || act.evict) && (idx < act.last);
        load  = ((act.hit || act.evict) && (idx == act.last))
             || (act.insert && (idx == lkp.occ));
        key_next = key_reg;
        if (shift)
        begin
            key_next = nbr_key;
        end
        else if (load)
        begin
            key_next = lkp.key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act.en)
        begin
            key_reg <= key_next;
        end
    end

endmodule

// ===== sv/lru_cache_hit_cost_tracker_core.sv =====
// top level of the lru cache hit cost tracker: cell chain, occupancy, cost and handshakes
`timescale 1ns / 1ps

// channel   signals                              direction  item
// in        in_valid in_ready key_bytes start_req  input      one key lookup
// out       out_valid out_ready hit total_cost     output     one result per key
// cfg       cfg_valid cfg_ready cfg_data           input      cache capacity write
//
// one item per cycle unless the output stalls; the result appears in the output register
// the cycle after the key is taken
// the rate is set by the combinational broadcast compare over all cells and the
// one-step shift of the chain, which lands in the same edge as the result
// a stalled result holds the output register; a new key is taken in the same
// cycle the held result leaves; cfg is always ready
// reset clears occupancy, cost, capacity and the output valid; keys need no reset

module lru_cache_hit_cost_tracker_core
    import lcht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KEY_W-1:0]  key_bytes,
    input  logic              start_req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic [COST_W-1:0] total_cost,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data
);

    // configuration
    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  cap_eff;

    // state
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  occ_next;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              hit_reg;

    // datapath
    logic              accept;
    logic [CNT_W-1:0]  occ_eff;
    logic              found;
    logic [COST_W-1:0] cost_base;
    logic [COST_W:0]   cost_sum;
    lookup_t           lkp;
    action_t           act;

    // chain wiring: seen ripples from the oldest entry up, keys move down
    logic [MAX_ENTRIES:0]   seen;
    logic [KEY_W-1:0]       cell_key [MAX_ENTRIES];
    logic [KEY_W-1:0]       nbr_key  [MAX_ENTRIES];

    assign cfg_ready  = 1'b1;
    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign total_cost = cost_reg;

    // capacity above the cell count acts as the cell count
    always_comb
    begin
        if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES))
        begin
            cap_eff = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    // start empties the cache before the lookup
    assign occ_eff = start_req ? '0 : occ_reg;
    assign lkp.key = fold_key(key_bytes);
    assign lkp.occ = occ_eff;

    assign seen[0] = 1'b0;
    assign found   = seen[MAX_ENTRIES];

    always_comb
    begin
        act.en     = accept;
        act.hit    = found;
        // miss with a full cache drops the oldest entry, if there is one
        act.evict  = !found && (occ_eff >= cap_eff) && (cap_eff != '0) && (occ_eff != '0);
        act.insert = !found && (occ_eff < cap_eff);
        act.last   = occ_eff - CNT_W'(1);
        occ_next   = occ_eff + CNT_W'(act.insert);
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        if (g == MAX_ENTRIES - 1)
        begin : g_top
            assign nbr_key[g] = '0;
        end
        else
        begin : g_mid
            assign nbr_key[g] = cell_key[g+1];
        end

        lcht_cell u_cell (
            .clk      (clk),
            .idx      (CNT_W'(g)),
            .lkp      (lkp),
            .act      (act),
            .seen_in  (seen[g]),
            .nbr_key  (nbr_key[g]),
            .seen_out (seen[g+1]),
            .key_out  (cell_key[g])
        );
    end

    // running cost, saturating at all ones
    always_comb
    begin
        cost_base = start_req ? '0 : cost_reg;
        cost_sum  = {1'b0, cost_base} + {1'b0, (found ? HIT_COST : MISS_COST)};
        cost_next = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
        out_valid_next = accept || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= '0;
            occ_reg       <= '0;
            cost_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                occ_reg  <= occ_next;
                cost_reg <= cost_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg <= found;
        end
    end

endmodule

// ===== sv/lcht_checker.sv =====
// port-level checks for the lru cache hit cost tracker, bound to the top level
`timescale 1ns / 1ps

`include "lru_cache_hit_cost_tracker_core_macros.svh"

module lcht_checker
    import lcht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              start_req,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              hit,
    input  logic [COST_W-1:0] total_cost
);

    // a held result stays put
    `LCHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hit) && $stable(total_cost))

    // no new key while a result is stuck
    `LCHT_ASSERT_IMPLY(a_in_blocked, clk, rst_n, out_valid && !out_ready, !in_ready)

    // a start always misses on an empty cache with fresh cost
    `LCHT_ASSERT_NEXT(a_start_miss, clk, rst_n, in_valid && in_ready && start_req, out_valid && !hit && total_cost == MISS_COST)

    // without a start the cost never goes down
    `LCHT_ASSERT_NEXT(a_cost_grows, clk, rst_n, in_valid && in_ready && !start_req && out_valid, total_cost > $past(total_cost) || total_cost == '1)

    // every result carries some cost
    `LCHT_ASSERT_IMPLY(a_cost_nonzero, clk, rst_n, out_valid, total_cost != '0)

endmodule

bind lru_cache_hit_cost_tracker_core lcht_checker u_lcht_checker (.*);
